// ----- hdl/dit_pkg.sv -----
package dit_pkg;

  typedef enum logic [1:0] {
    CMD_WRITE   = 2'd0,
    CMD_READ    = 2'd1,
    CMD_ADVANCE = 2'd2,
    CMD_ACK     = 2'd3
  } cmd_t;

  localparam logic [3:0] ADDR_PORT_A = 4'h0;
  localparam logic [3:0] ADDR_PORT_B = 4'h1;
  localparam logic [3:0] ADDR_DDR_A  = 4'h2;
  localparam logic [3:0] ADDR_DDR_B  = 4'h3;
  localparam logic [3:0] ADDR_TA_LO  = 4'h4;
  localparam logic [3:0] ADDR_TA_HI  = 4'h5;
  localparam logic [3:0] ADDR_TB_LO  = 4'h6;
  localparam logic [3:0] ADDR_TB_HI  = 4'h7;
  localparam logic [3:0] ADDR_SDR    = 4'hc;
  localparam logic [3:0] ADDR_ICR    = 4'hd;
  localparam logic [3:0] ADDR_CRA    = 4'he;
  localparam logic [3:0] ADDR_CRB    = 4'hf;

  localparam logic [15:0] COUNT_RESET = 16'hffff;
  localparam logic [7:0]  PORT_A_CHIP0 = 8'hff;
  localparam logic [7:0]  PORT_A_CHIP1 = 8'hd0;
  localparam logic [7:0]  PORT_B_CHIP0 = 8'hff;

  localparam int CTRL_START   = 0;
  localparam int CTRL_ONESHOT = 3;
  localparam int CTRL_LOAD    = 4;
  localparam int ICR_SET      = 7;

  typedef struct packed {
    logic [15:0] advance_cycles;
    logic [7:0]  write_data;
    logic [3:0]  address;
    logic        chip;
    cmd_t        command;
  } item_t;

  typedef struct packed {
    logic        adv;
    logic [15:0] cycles;
    logic        wr_lo;
    logic        wr_hi;
    logic        wr_ctrl;
    logic        wr_ien;
    logic        ack;
    logic [7:0]  data;
  } timer_cmd_t;

  typedef struct packed {
    logic [15:0] count;
    logic [7:0]  control;
    logic        triggered;
    logic        fire;
    logic [15:0] count_nxt;
    logic        running_nxt;
  } timer_stat_t;

  typedef struct packed {
    logic        expiry_valid;
    logic [15:0] next_expiry;
    logic        interrupt_pending;
    logic [7:0]  read_data;
  } result_t;

endpackage

// ----- hdl/dit_in_stage.sv -----
module dit_in_stage (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [31:0]     in_tdata,
  input  logic [2:0]      in_tuser,
  input  logic            take,
  output dit_pkg::item_t  item,
  output logic            item_valid
);

  logic           valid_r;
  dit_pkg::item_t item_r;

  assign in_tready  = !valid_r || take;
  assign item       = item_r;
  assign item_valid = valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tready) begin
      valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.command        <= dit_pkg::cmd_t'(in_tuser[1:0]);
      item_r.chip           <= in_tuser[2];
      item_r.address        <= in_tdata[3:0];
      item_r.write_data     <= in_tdata[11:4];
      item_r.advance_cycles <= in_tdata[27:12];
    end
  end

endmodule

// ----- hdl/dit_timer.sv -----
module dit_timer (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dit_pkg::timer_cmd_t   cmd,
  output dit_pkg::timer_stat_t  stat
);

  logic [15:0] count_r, count_nxt;
  logic [15:0] latch_r, latch_nxt;
  logic [7:0]  ctrl_r, ctrl_nxt;
  logic        ien_r, ien_nxt;
  logic        trig_r, trig_nxt;
  logic        expire;
  logic        fire;

  always_comb begin
    count_nxt = count_r;
    latch_nxt = latch_r;
    ctrl_nxt  = ctrl_r;
    ien_nxt   = ien_r;
    trig_nxt  = trig_r;
    expire    = cmd.adv && ctrl_r[dit_pkg::CTRL_START] && !(count_r > cmd.cycles);
    fire      = expire && ien_r;

    if (cmd.adv && ctrl_r[dit_pkg::CTRL_START]) begin
      if (expire) begin
        count_nxt = latch_r;
        if (ien_r) begin
          trig_nxt = 1'b1;
        end
        if (ctrl_r[dit_pkg::CTRL_ONESHOT]) begin
          ctrl_nxt[dit_pkg::CTRL_START] = 1'b0;
        end
      end else begin
        count_nxt = count_r - cmd.cycles;
      end
    end
    if (cmd.wr_lo) begin
      latch_nxt[7:0] = cmd.data;
    end
    if (cmd.wr_hi) begin
      latch_nxt[15:8] = cmd.data;
      if (!ctrl_r[dit_pkg::CTRL_START]) begin
        count_nxt = {cmd.data, latch_r[7:0]};
      end
    end
    if (cmd.wr_ctrl) begin
      ctrl_nxt = cmd.data;
      ctrl_nxt[dit_pkg::CTRL_LOAD] = 1'b0;
      if (cmd.data[dit_pkg::CTRL_LOAD]) begin
        count_nxt = latch_r;
      end
    end
    if (cmd.wr_ien) begin
      ien_nxt = cmd.data[dit_pkg::ICR_SET];
    end
    if (cmd.ack) begin
      trig_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= dit_pkg::COUNT_RESET;
      latch_r <= dit_pkg::COUNT_RESET;
      ctrl_r  <= '0;
      ien_r   <= 1'b0;
      trig_r  <= 1'b0;
    end else begin
      count_r <= count_nxt;
      latch_r <= latch_nxt;
      ctrl_r  <= ctrl_nxt;
      ien_r   <= ien_nxt;
      trig_r  <= trig_nxt;
    end
  end

  assign stat.count       = count_r;
  assign stat.control     = ctrl_r;
  assign stat.triggered   = trig_r;
  assign stat.fire        = fire;
  assign stat.count_nxt   = count_nxt;
  assign stat.running_nxt = ctrl_nxt[dit_pkg::CTRL_START];

  a_load_bit_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !ctrl_r[dit_pkg::CTRL_LOAD])
    else $error("load bit stored in control register");

  a_fire_sets_trigger: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> trig_r)
    else $error("expiry with interrupt enabled did not set trigger");

endmodule

// ----- hdl/dual_interval_timer_registers.sv -----
// Register block of up to two interface-adapter chips, each with two 16-bit
// down-counting timers. Items carry a bus write, a bus read, a time advance or
// an interrupt acknowledge, and every item gives exactly one result item with
// the read byte, the acknowledge outcome, the nearest expiry and a status bit.
// The block takes one item per clock cycle as long as results are taken. Each
// item waits in the input register until the result register is free or being
// read; then all timers update in parallel (subtract, compare and reload) and
// the result register is loaded together with them. The input register lets
// one new item in while a result still waits to be taken.
module dual_interval_timer_registers #(
  parameter int NUM_CHIPS = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // address, write_data, advance_cycles
  input  logic [2:0]  in_tuser,   // command, chip
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // read_data, interrupt_pending, next_expiry, expiry_valid
  output logic [0:0]  out_tuser   // status
);

  localparam int NUM_TIMERS = 2 * NUM_CHIPS;

  dit_pkg::item_t       item;
  logic                 item_valid;
  logic                 take;
  dit_pkg::timer_cmd_t  tcmd [NUM_TIMERS];
  dit_pkg::timer_stat_t tstat [NUM_TIMERS];

  logic [7:0]           serial_r [NUM_CHIPS];
  logic [1:0]           flags_r  [NUM_CHIPS];
  logic [NUM_CHIPS-1:0] chip_sel;

  logic                 chip_ok;
  logic                 op_wr;
  logic                 op_rd;
  logic                 op_adv;
  logic                 op_ack;
  logic                 wr_bad;
  logic                 rd_bad;
  logic [7:0]           rd_val;
  logic [15:0]          sel_count;
  logic [7:0]           sel_serial;
  logic [1:0]           sel_flags;
  logic [7:0]           sel_ctrl;
  logic                 pend;
  logic [16:0]          best;

  logic                 out_valid_r;
  dit_pkg::result_t     res_r, res_nxt;
  logic                 status_r, status_nxt;

  dit_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .take       (take),
    .item       (item),
    .item_valid (item_valid)
  );

  assign take    = item_valid && (!out_valid_r || out_tready);
  assign chip_ok = (NUM_CHIPS > 1) || !item.chip;
  assign op_adv  = take && (item.command == dit_pkg::CMD_ADVANCE);
  assign op_wr   = take && chip_ok && (item.command == dit_pkg::CMD_WRITE);
  assign op_rd   = take && chip_ok && (item.command == dit_pkg::CMD_READ);
  assign op_ack  = take && chip_ok && (item.command == dit_pkg::CMD_ACK);

  always_comb begin
    for (int c = 0; c < NUM_CHIPS; c++) begin
      chip_sel[c] = (item.chip == 1'(c));
    end
  end

  always_comb begin
    unique case (item.address) inside
      dit_pkg::ADDR_PORT_A, dit_pkg::ADDR_DDR_A, dit_pkg::ADDR_DDR_B,
      dit_pkg::ADDR_TA_LO, dit_pkg::ADDR_TA_HI, dit_pkg::ADDR_TB_LO,
      dit_pkg::ADDR_TB_HI, dit_pkg::ADDR_SDR, dit_pkg::ADDR_ICR,
      dit_pkg::ADDR_CRA, dit_pkg::ADDR_CRB: wr_bad = 1'b0;
      default: wr_bad = 1'b1;
    endcase
  end

  genvar g;
  generate
    for (g = 0; g < NUM_TIMERS; g++) begin : g_timer
      localparam int CH = g / 2;
      localparam logic [3:0] LO_ADDR = (g % 2 == 1) ? dit_pkg::ADDR_TB_LO : dit_pkg::ADDR_TA_LO;
      localparam logic [3:0] HI_ADDR = (g % 2 == 1) ? dit_pkg::ADDR_TB_HI : dit_pkg::ADDR_TA_HI;
      localparam logic [3:0] CR_ADDR = (g % 2 == 1) ? dit_pkg::ADDR_CRB : dit_pkg::ADDR_CRA;
      logic wr_here;

      assign wr_here = op_wr && chip_sel[CH];

      assign tcmd[g].adv     = op_adv;
      assign tcmd[g].cycles  = item.advance_cycles;
      assign tcmd[g].data    = item.write_data;
      assign tcmd[g].wr_lo   = wr_here && (item.address == LO_ADDR);
      assign tcmd[g].wr_hi   = wr_here && (item.address == HI_ADDR);
      assign tcmd[g].wr_ctrl = wr_here && (item.address == CR_ADDR);
      assign tcmd[g].wr_ien  = wr_here && (item.address == dit_pkg::ADDR_ICR)
                               && item.write_data[g % 2];
      assign tcmd[g].ack     = op_ack && chip_sel[CH];

      dit_timer u_timer (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (tcmd[g]),
        .stat  (tstat[g])
      );
    end

    for (g = 0; g < NUM_CHIPS; g++) begin : g_chip
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          serial_r[g] <= '0;
          flags_r[g]  <= '0;
        end else begin
          if (op_wr && chip_sel[g] && (item.address == dit_pkg::ADDR_SDR)) begin
            serial_r[g] <= item.write_data;
          end
          if (op_rd && chip_sel[g] && (item.address == dit_pkg::ADDR_ICR)) begin
            flags_r[g] <= '0;
          end else if (op_adv) begin
            flags_r[g] <= flags_r[g] | {tstat[2*g+1].fire, tstat[2*g].fire};
          end
        end
      end
    end
  endgenerate

  always_comb begin
    sel_count  = '0;
    sel_serial = '0;
    sel_flags  = '0;
    sel_ctrl   = '0;
    pend       = 1'b0;
    for (int c = 0; c < NUM_CHIPS; c++) begin
      if (chip_sel[c]) begin
        sel_count  = tstat[2*c].count;
        sel_serial = serial_r[c];
        sel_flags  = flags_r[c];
        sel_ctrl   = tstat[2*c].control;
        pend       = tstat[2*c].triggered || tstat[2*c+1].triggered;
      end
    end
  end

  always_comb begin
    rd_val = '0;
    rd_bad = 1'b0;
    unique case (item.address)
      dit_pkg::ADDR_PORT_A: rd_val = item.chip ? dit_pkg::PORT_A_CHIP1 : dit_pkg::PORT_A_CHIP0;
      dit_pkg::ADDR_PORT_B: begin
        if (item.chip) begin
          rd_bad = 1'b1;
        end else begin
          rd_val = dit_pkg::PORT_B_CHIP0;
        end
      end
      dit_pkg::ADDR_TA_LO: rd_val = sel_count[7:0];
      dit_pkg::ADDR_TA_HI: rd_val = sel_count[15:8];
      dit_pkg::ADDR_SDR:   rd_val = sel_serial;
      dit_pkg::ADDR_ICR:   rd_val = {(sel_flags != 2'b00), 5'b0, sel_flags};
      dit_pkg::ADDR_CRA:   rd_val = sel_ctrl;
      default:             rd_bad = 1'b1;
    endcase
  end

  always_comb begin
    best = 17'h10000;
    for (int t = 0; t < NUM_TIMERS; t++) begin
      if (tstat[t].running_nxt && ({1'b0, tstat[t].count_nxt} < best)) begin
        best = {1'b0, tstat[t].count_nxt};
      end
    end
  end

  always_comb begin
    res_nxt.read_data         = (op_rd && !rd_bad) ? rd_val : 8'h00;
    res_nxt.interrupt_pending = op_ack && pend;
    res_nxt.expiry_valid      = !best[16];
    res_nxt.next_expiry       = best[16] ? 16'h0000 : best[15:0];
    status_nxt                = (take && !op_adv && !chip_ok) || (op_wr && wr_bad)
                                || (op_rd && rd_bad);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_r    <= res_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, res_r};
  assign out_tuser  = status_r;

  a_expiry_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !res_r.expiry_valid) |-> (res_r.next_expiry == 16'h0000))
    else $error("next expiry not zero with no timer running");

  a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r) |-> (res_r.read_data == 8'h00 && !res_r.interrupt_pending))
    else $error("error result carries data");

  a_item_held: assert property (@(posedge clk) disable iff (!rst_n)
    (item_valid && !take) |=> item_valid)
    else $error("stalled item dropped from input register");

endmodule

// ----- tb/sv/dit_result_checker.sv -----
`timescale 1ns / 1ps

module dit_result_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,   // address, write_data, advance_cycles
  input  logic [2:0]  in_tuser,   // command, chip
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,  // read_data, interrupt_pending, next_expiry, expiry_valid
  input  logic [0:0]  out_tuser,  // status
  output int          mismatches,
  output int          outstanding
);

  typedef struct packed {
    logic [7:0]  read_data;
    logic        interrupt_pending;
    logic [15:0] next_expiry;
    logic        expiry_valid;
    logic        status;
  } timer_reply_t;

  logic [15:0] count_m[4];
  logic [15:0] latch_m[4];
  logic [7:0]  control_m[4];
  logic        running_m[4];
  logic        one_shot_m[4];
  logic        irq_en_m[4];
  logic        irq_trig_m[4];
  logic [1:0]  irq_flag_m[2];
  logic [7:0]  serial_m[2];

  timer_reply_t replies_due[$];

  task automatic apply_bus_item(input dit_pkg::cmd_t cmd, input logic chip,
                                input logic [3:0] addr,
                                input logic [7:0] wd, input logic [15:0] cyc,
                                output timer_reply_t r);
    int base;
    int t;
    logic [16:0] nearest;
    r = '0;
    base = chip ? 2 : 0;
    nearest = 17'h10000;
    if (cmd == dit_pkg::CMD_ADVANCE) begin
      for (t = 0; t < 4; t++) begin
        if (running_m[t]) begin
          if (count_m[t] > cyc) begin
            count_m[t] = count_m[t] - cyc;
          end else begin
            if (irq_en_m[t]) begin
              irq_trig_m[t] = 1'b1;
              irq_flag_m[t / 2][t % 2] = 1'b1;
            end
            count_m[t] = latch_m[t];
            if (one_shot_m[t]) begin
              running_m[t] = 1'b0;
              control_m[t][dit_pkg::CTRL_START] = 1'b0;
            end
          end
        end
      end
    end else if (cmd == dit_pkg::CMD_WRITE) begin
      case (addr)
        dit_pkg::ADDR_PORT_A, dit_pkg::ADDR_DDR_A, dit_pkg::ADDR_DDR_B: ;
        dit_pkg::ADDR_TA_LO, dit_pkg::ADDR_TB_LO: begin
          t = base + ((addr == dit_pkg::ADDR_TB_LO) ? 1 : 0);
          latch_m[t][7:0] = wd;
        end
        dit_pkg::ADDR_TA_HI, dit_pkg::ADDR_TB_HI: begin
          t = base + ((addr == dit_pkg::ADDR_TB_HI) ? 1 : 0);
          latch_m[t][15:8] = wd;
          if (!control_m[t][dit_pkg::CTRL_START]) count_m[t] = latch_m[t];
        end
        dit_pkg::ADDR_SDR: serial_m[chip] = wd;
        dit_pkg::ADDR_ICR: begin
          for (int k = 0; k < 2; k++)
            if (wd[k]) irq_en_m[base + k] = wd[dit_pkg::ICR_SET];
        end
        dit_pkg::ADDR_CRA, dit_pkg::ADDR_CRB: begin
          t = base + ((addr == dit_pkg::ADDR_CRB) ? 1 : 0);
          control_m[t] = wd;
          control_m[t][dit_pkg::CTRL_LOAD] = 1'b0;
          running_m[t] = wd[dit_pkg::CTRL_START];
          one_shot_m[t] = wd[dit_pkg::CTRL_ONESHOT];
          if (wd[dit_pkg::CTRL_LOAD]) count_m[t] = latch_m[t];
        end
        default: r.status = 1'b1;
      endcase
    end else if (cmd == dit_pkg::CMD_READ) begin
      case (addr)
        dit_pkg::ADDR_PORT_A:
          r.read_data = chip ? dit_pkg::PORT_A_CHIP1 : dit_pkg::PORT_A_CHIP0;
        dit_pkg::ADDR_PORT_B: begin
          if (chip) r.status = 1'b1;
          else r.read_data = dit_pkg::PORT_B_CHIP0;
        end
        dit_pkg::ADDR_TA_LO: r.read_data = count_m[base][7:0];
        dit_pkg::ADDR_TA_HI: r.read_data = count_m[base][15:8];
        dit_pkg::ADDR_SDR:   r.read_data = serial_m[chip];
        dit_pkg::ADDR_ICR: begin
          r.read_data = {|irq_flag_m[chip], 5'b0, irq_flag_m[chip]};
          irq_flag_m[chip] = 2'b0;
        end
        dit_pkg::ADDR_CRA:   r.read_data = control_m[base];
        default:             r.status = 1'b1;
      endcase
    end else begin
      for (int k = 0; k < 2; k++) begin
        if (irq_trig_m[base + k]) begin
          irq_trig_m[base + k] = 1'b0;
          r.interrupt_pending = 1'b1;
        end
      end
    end
    for (t = 0; t < 4; t++)
      if (running_m[t] && count_m[t] < nearest) nearest = count_m[t];
    r.next_expiry = nearest[15:0];
    r.expiry_valid = ~nearest[16];
  endtask

  always @(posedge clk) begin
    timer_reply_t want;
    timer_reply_t got;
    if (!rst_n) begin
      for (int t = 0; t < 4; t++) begin
        count_m[t] = dit_pkg::COUNT_RESET;
        latch_m[t] = dit_pkg::COUNT_RESET;
        control_m[t] = '0;
        running_m[t] = 1'b0;
        one_shot_m[t] = 1'b0;
        irq_en_m[t] = 1'b0;
        irq_trig_m[t] = 1'b0;
      end
      for (int c = 0; c < 2; c++) begin
        irq_flag_m[c] = '0;
        serial_m[c] = '0;
      end
      replies_due.delete();
    end else begin
      if (in_tvalid && in_tready) begin
        apply_bus_item(dit_pkg::cmd_t'(in_tuser[1:0]), in_tuser[2], in_tdata[3:0],
                       in_tdata[11:4], in_tdata[27:12], want);
        replies_due.push_back(want);
      end
      if (out_tvalid && out_tready) begin
        got.read_data = out_tdata[7:0];
        got.interrupt_pending = out_tdata[8];
        got.next_expiry = out_tdata[24:9];
        got.expiry_valid = out_tdata[25];
        got.status = out_tuser[0];
        if (replies_due.size() == 0) begin
          $error("result item with no expectation waiting");
          mismatches++;
        end else begin
          want = replies_due.pop_front();
          if (got.read_data !== want.read_data) begin
            $error("read_data: expected %0h, actual %0h", want.read_data, got.read_data);
            mismatches++;
          end
          if (got.interrupt_pending !== want.interrupt_pending) begin
            $error("interrupt_pending: expected %0h, actual %0h", want.interrupt_pending,
                   got.interrupt_pending);
            mismatches++;
          end
          if (got.next_expiry !== want.next_expiry) begin
            $error("next_expiry: expected %0h, actual %0h", want.next_expiry,
                   got.next_expiry);
            mismatches++;
          end
          if (got.expiry_valid !== want.expiry_valid) begin
            $error("expiry_valid: expected %0h, actual %0h", want.expiry_valid,
                   got.expiry_valid);
            mismatches++;
          end
          if (got.status !== want.status) begin
            $error("status: expected %0h, actual %0h", want.status, got.status);
            mismatches++;
          end
        end
      end
    end
    outstanding = replies_due.size();
  end

endmodule

// ----- tb/sv/dual_interval_timer_registers_test.sv -----
`timescale 1ns / 1ps

module dual_interval_timer_registers_test;

  localparam int RANDOM_ITEMS   = 1400;
  localparam int QUIET_LIMIT    = 1000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic [2:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic [0:0]  out_tuser;
  int          mismatches;
  int          outstanding;
  int          quiet_cycles;
  bit          idle_on;

  dual_interval_timer_registers DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  dit_result_checker u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // The receiver stalls in bursts while idling is enabled, and never otherwise.
  initial begin
    int stall_left;
    stall_left = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (!idle_on) stall_left = 0;
      else if (stall_left == 0 && $urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 14);
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic send_item(input dit_pkg::cmd_t cmd, input logic chip, input logic [3:0] addr,
                           input logic [7:0] wd, input logic [15:0] cyc);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {4'b0, cyc, wd, addr};
    in_tuser <= {chip, cmd};
    do @(posedge clk); while (!in_tready);
  endtask

  initial begin
    dit_pkg::cmd_t cmd;
    logic        chip;
    logic [3:0]  addr;
    logic [7:0]  wd;
    logic [15:0] cyc;
    int          pick;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    idle_on = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_item(dit_pkg::CMD_READ, 1'b0, dit_pkg::ADDR_PORT_A, 8'h00, 16'h0000);
    send_item(dit_pkg::CMD_READ, 1'b1, dit_pkg::ADDR_PORT_A, 8'h00, 16'h0000);
    send_item(dit_pkg::CMD_READ, 1'b0, dit_pkg::ADDR_PORT_B, 8'h00, 16'h0000);
    send_item(dit_pkg::CMD_READ, 1'b1, dit_pkg::ADDR_PORT_B, 8'h00, 16'h0000);
    send_item(dit_pkg::CMD_READ, 1'b0, dit_pkg::ADDR_DDR_A, 8'h00, 16'h0000);
    send_item(dit_pkg::CMD_WRITE, 1'b1, 4'h8, 8'hff, 16'h0000);
    send_item(dit_pkg::CMD_WRITE, 1'b0, dit_pkg::ADDR_DDR_B, 8'h5a, 16'h0000);
    send_item(dit_pkg::CMD_WRITE, 1'b0, dit_pkg::ADDR_ICR, 8'h83, 16'h0000);
    send_item(dit_pkg::CMD_WRITE, 1'b0, dit_pkg::ADDR_TA_LO, 8'h05, 16'h0000);
    send_item(dit_pkg::CMD_WRITE, 1'b0, dit_pkg::ADDR_TA_HI, 8'h00, 16'h0000);
    send_item(dit_pkg::CMD_WRITE, 1'b0, dit_pkg::ADDR_CRA, 8'h09, 16'h0000);
    send_item(dit_pkg::CMD_WRITE, 1'b1, dit_pkg::ADDR_SDR, 8'ha5, 16'h0000);
    send_item(dit_pkg::CMD_READ, 1'b1, dit_pkg::ADDR_SDR, 8'h00, 16'h0000);
    // An advance equal to the count expires the one-shot timer and stops it.
    send_item(dit_pkg::CMD_ADVANCE, 1'b1, 4'hf, 8'hff, 16'd5);
    send_item(dit_pkg::CMD_READ, 1'b0, dit_pkg::ADDR_ICR, 8'h00, 16'h0000);
    send_item(dit_pkg::CMD_READ, 1'b0, dit_pkg::ADDR_ICR, 8'h00, 16'h0000);
    send_item(dit_pkg::CMD_ACK, 1'b0, 4'hf, 8'hff, 16'hffff);
    send_item(dit_pkg::CMD_ACK, 1'b0, 4'h0, 8'h00, 16'h0000);
    send_item(dit_pkg::CMD_WRITE, 1'b0, dit_pkg::ADDR_TB_LO, 8'h00, 16'h0000);
    send_item(dit_pkg::CMD_WRITE, 1'b0, dit_pkg::ADDR_TB_HI, 8'h00, 16'h0000);
    send_item(dit_pkg::CMD_WRITE, 1'b0, dit_pkg::ADDR_CRB, 8'h11, 16'h0000);
    // A zero count with a zero advance still counts as expiry.
    send_item(dit_pkg::CMD_ADVANCE, 1'b0, 4'h0, 8'h00, 16'h0000);
    send_item(dit_pkg::CMD_READ, 1'b0, dit_pkg::ADDR_CRA, 8'h00, 16'h0000);
    send_item(dit_pkg::CMD_WRITE, 1'b1, dit_pkg::ADDR_CRA, 8'hff, 16'h0000);
    send_item(dit_pkg::CMD_ADVANCE, 1'b0, 4'h0, 8'h00, 16'hffff);
    send_item(dit_pkg::CMD_READ, 1'b1, dit_pkg::ADDR_TA_HI, 8'h00, 16'h0000);
    send_item(dit_pkg::CMD_WRITE, 1'b0, dit_pkg::ADDR_ICR, 8'h03, 16'h0000);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 100 == 0) idle_on = (i < RANDOM_ITEMS - 200) && ($urandom_range(0, 3) != 0);
      if (i == RANDOM_ITEMS / 2) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
        while (outstanding != 0) @(negedge clk);
      end
      chip = 1'($urandom_range(0, 1));
      addr = 4'($urandom_range(0, 15));
      wd = 8'($urandom_range(0, 255));
      cyc = 16'($urandom_range(0, 65535));
      pick = $urandom_range(0, 99);
      if (pick < 32) begin
        cmd = dit_pkg::CMD_WRITE;
        case ($urandom_range(0, 3))
          0: begin
            addr = $urandom_range(0, 1) ? dit_pkg::ADDR_TA_LO : dit_pkg::ADDR_TB_LO;
            if ($urandom_range(0, 1)) wd = 8'($urandom_range(0, 40));
          end
          1: begin
            addr = $urandom_range(0, 1) ? dit_pkg::ADDR_TA_HI : dit_pkg::ADDR_TB_HI;
            if ($urandom_range(0, 3) != 0) wd = 8'h00;
          end
          2: begin
            addr = $urandom_range(0, 1) ? dit_pkg::ADDR_CRA : dit_pkg::ADDR_CRB;
            wd[dit_pkg::CTRL_START] = ($urandom_range(0, 3) != 0);
          end
          default: addr = dit_pkg::ADDR_ICR;
        endcase
      end else if (pick < 57) begin
        cmd = dit_pkg::CMD_ADVANCE;
        case ($urandom_range(0, 2))
          0: cyc = 16'($urandom_range(0, 40));
          1: cyc = 16'($urandom_range(0, 1000));
          default: ;
        endcase
      end else if (pick < 75) begin
        cmd = dit_pkg::CMD_READ;
        case ($urandom_range(0, 5))
          0: addr = dit_pkg::ADDR_TA_LO;
          1: addr = dit_pkg::ADDR_TA_HI;
          2: addr = dit_pkg::ADDR_ICR;
          3: addr = dit_pkg::ADDR_CRA;
          4: addr = dit_pkg::ADDR_SDR;
          default: ;
        endcase
      end else if (pick < 88) begin
        cmd = dit_pkg::CMD_ACK;
      end else begin
        cmd = dit_pkg::cmd_t'(2'($urandom_range(0, 3)));
      end
      send_item(cmd, chip, addr, wd, cyc);
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
